/* design/hashed_block_cache_timestamp_lru_assert.svh */
// ----------------------------------------------------------------------------
// hashed block cache assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef HASHED_BLOCK_CACHE_TIMESTAMP_LRU_ASSERT_SVH
`define HASHED_BLOCK_CACHE_TIMESTAMP_LRU_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define HBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbc assertion failed");

// consequent holds in the cycle after the antecedent
`define HBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbc assertion failed");

`endif

/* design/hbc_pkg.sv */
// ----------------------------------------------------------------------------
// hbc_pkg
// shared sizes, request codes and beat types of the block cache tag store
// ----------------------------------------------------------------------------
`default_nettype none

package hbc_pkg;

    // cache geometry (SETS must be a power of two, set taken from low bits)
    localparam int SETS    = 8;
    localparam int WAYS    = 4;
    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_W   = $clog2(WAYS);

    // request queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // request codes
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_PIN    = 2'd1;
    localparam logic [1:0] FUNC_UNPIN  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // one way of a set
    typedef struct packed {
        logic [15:0] dev;
        logic [31:0] blk;
        logic        valid;
        logic [31:0] stamp;
    } way_t;

    // one set row of the tag store
    typedef way_t [WAYS-1:0] row_t;

    // classified request
    typedef struct packed {
        logic [1:0]       op;
        logic [15:0]      device;
        logic [31:0]      blk;
        logic [1:0]       way_sel;
        logic             way_ok;
        logic [31:0]      now;
        logic [SET_W-1:0] set;
    } item_t;

    // head of the request queue
    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

endpackage

`default_nettype wire

/* design/hbc_front.sv */
// ----------------------------------------------------------------------------
// hbc_front
// accepts request beats, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
`default_nettype none

module hbc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    func,
    input  wire logic [15:0]   device,
    input  wire logic [31:0]   block_number,
    input  wire logic [1:0]    way_select,
    input  wire logic [31:0]   current_time,
    input  wire logic          pop,
    output hbc_pkg::qhead_t    head
);

    hbc_pkg::item_t                 q_mem [hbc_pkg::QDEPTH];
    logic [hbc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [hbc_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [hbc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [hbc_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [hbc_pkg::QCNT_W-1:0]     count_reg;
    logic [hbc_pkg::QCNT_W-1:0]     count_next;
    hbc_pkg::item_t                 new_item;
    logic                           push;
    logic                           do_pop;

    // classify the incoming beat
    always_comb
    begin
        new_item.op      = func;
        new_item.device  = device;
        new_item.blk     = block_number;
        new_item.way_sel = way_select;
        new_item.way_ok  = ({1'b0, way_select} < 3'(hbc_pkg::WAYS));
        new_item.now     = current_time;
        new_item.set     = block_number[hbc_pkg::SET_W-1:0];
    end

    // queue handshake
    assign busy   = (count_reg == hbc_pkg::QCNT_W'(hbc_pkg::QDEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == hbc_pkg::QPTR_W'(hbc_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == hbc_pkg::QPTR_W'(hbc_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

/* design/hbc_back.sv */
// ----------------------------------------------------------------------------
// hbc_back
// reads a set row, resolves hit or lru victim, writes the row back and
// drives the result beat
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_block_cache_timestamp_lru_assert.svh"

module hbc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hbc_pkg::qhead_t head,
    output logic               pop,
    output logic               done,
    output logic [2:0]         set_index,
    output logic [1:0]         way_index,
    output logic               hit,
    output logic               needs_fill
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    hbc_pkg::row_t               row_mem [hbc_pkg::SETS];
    hbc_pkg::row_t               rd_row_reg;
    logic [hbc_pkg::SETS-1:0]    row_init_reg;
    logic [hbc_pkg::SETS-1:0]    row_init_next;
    hbc_pkg::item_t              item_reg;
    logic                        state_reg;
    logic                        state_next;

    logic                        done_reg;
    logic [2:0]                  set_index_reg;
    logic [1:0]                  way_index_reg;
    logic                        hit_reg;
    logic                        fill_reg;

    hbc_pkg::row_t               row;
    hbc_pkg::row_t               new_row;
    logic                        lookup_hit;
    logic [hbc_pkg::WAY_W-1:0]   hit_way;
    logic [hbc_pkg::WAY_W-1:0]   lru_way;
    logic [31:0]                 lru_stamp;
    logic [hbc_pkg::WAY_W-1:0]   sel_way;
    logic                        wr_en;
    logic [2:0]                  res_set;
    logic [1:0]                  res_way;
    logic                        res_fill;
    logic                        exec_lookup;
    logic                        exec_other;

    // sequencer: pop and read in idle, resolve and write back in exec
    assign pop = (state_reg == ST_IDLE) && head.valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pop) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // rows never written read as zero
    assign row = row_init_reg[item_reg.set] ? rd_row_reg : '0;

    // tag match, lowest matching way wins
    always_comb
    begin
        lookup_hit = 1'b0;
        hit_way    = '0;
        for (int w = hbc_pkg::WAYS - 1; w >= 0; w--)
        begin
            if (row[w].dev == item_reg.device && row[w].blk == item_reg.blk)
            begin
                lookup_hit = 1'b1;
                hit_way    = hbc_pkg::WAY_W'(w);
            end
        end
    end

    // smallest stamp, later way wins on ties
    always_comb
    begin
        lru_way   = '0;
        lru_stamp = row[0].stamp;
        for (int w = 1; w < hbc_pkg::WAYS; w++)
        begin
            if (row[w].stamp <= lru_stamp)
            begin
                lru_way   = hbc_pkg::WAY_W'(w);
                lru_stamp = row[w].stamp;
            end
        end
    end

    assign sel_way = lookup_hit ? hit_way : lru_way;

    // row update and result
    always_comb
    begin
        new_row  = row;
        res_set  = 3'(item_reg.set);
        res_way  = '0;
        res_fill = 1'b0;
        wr_en    = 1'b0;
        case (item_reg.op)
            hbc_pkg::FUNC_LOOKUP:
            begin
                wr_en                  = (state_reg == ST_EXEC);
                res_way                = 2'(sel_way);
                res_fill               = lookup_hit ? !row[sel_way].valid : 1'b1;
                new_row[sel_way].dev   = item_reg.device;
                new_row[sel_way].blk   = item_reg.blk;
                new_row[sel_way].valid = 1'b1;
                new_row[sel_way].stamp = item_reg.now;
            end
            hbc_pkg::FUNC_PIN, hbc_pkg::FUNC_UNPIN:
            begin
                wr_en   = (state_reg == ST_EXEC) && item_reg.way_ok;
                res_way = item_reg.way_sel;
                new_row[item_reg.way_sel[hbc_pkg::WAY_W-1:0]].stamp =
                    (item_reg.op == hbc_pkg::FUNC_PIN) ? item_reg.now : '0;
            end
            default:
            begin
                res_set = '0;
            end
        endcase
    end

    // row written flags
    always_comb
    begin
        row_init_next = row_init_reg;
        if (wr_en)
        begin
            row_init_next[item_reg.set] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_init_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_init_reg <= row_init_next;
            done_reg     <= (state_reg == ST_EXEC);
        end
    end

    // tag store row memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[item_reg.set] <= new_row;
        end
        if (pop)
        begin
            rd_row_reg <= row_mem[head.item.set];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head.item;
        end
        if (state_reg == ST_EXEC)
        begin
            set_index_reg <= res_set;
            way_index_reg <= res_way;
            hit_reg       <= (item_reg.op == hbc_pkg::FUNC_LOOKUP) && lookup_hit;
            fill_reg      <= (item_reg.op == hbc_pkg::FUNC_LOOKUP) && res_fill;
        end
    end

    assign done       = done_reg;
    assign set_index  = set_index_reg;
    assign way_index  = way_index_reg;
    assign hit        = hit_reg;
    assign needs_fill = fill_reg;

    // exec cycle split by request kind
    assign exec_lookup = (state_reg == ST_EXEC) && (item_reg.op == hbc_pkg::FUNC_LOOKUP);
    assign exec_other  = (state_reg == ST_EXEC) && (item_reg.op != hbc_pkg::FUNC_LOOKUP);

    // checks
    `HBC_ASSERT_NEXT(a_exec_gives_done, state_reg == ST_EXEC, done_reg)
    `HBC_ASSERT_NEXT(a_pop_enters_exec, pop, state_reg == ST_EXEC && !done_reg)
    `HBC_ASSERT_NEXT(a_miss_needs_fill, exec_lookup && !lookup_hit, fill_reg && !hit_reg)
    `HBC_ASSERT_NEXT(a_other_no_flags, exec_other, !hit_reg && !fill_reg)

endmodule

`default_nettype wire

/* design/hashed_block_cache_timestamp_lru.sv */
// ----------------------------------------------------------------------------
// hashed_block_cache_timestamp_lru
// tag store of a set-associative disk block cache with timestamp lru
// ----------------------------------------------------------------------------
// A request beat is taken at a rising edge with start high and busy low; busy
// rises only when the two-entry request queue is full. Each request gives one
// result beat on done, exactly one cycle long, which cannot be held off. The
// back end serves requests one at a time: a set row is read from the tag
// store in the idle state and resolved and written back in the exec state
// after it, so the next read waits for that write. A request passes the
// queue, idle and exec before done rises; its beat is taken as done ends.
// Rows never written read as zero, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_block_cache_timestamp_lru (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    func,
    input  wire logic [15:0]   device,
    input  wire logic [31:0]   block_number,
    input  wire logic [1:0]    way_select,
    input  wire logic [31:0]   current_time,
    output logic               done,
    output logic [2:0]         set_index,
    output logic [1:0]         way_index,
    output logic               hit,
    output logic               needs_fill
);

    hbc_pkg::qhead_t head;
    logic            pop;

    // request intake and queue
    hbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .device       (device),
        .block_number (block_number),
        .way_select   (way_select),
        .current_time (current_time),
        .pop          (pop),
        .head         (head)
    );

    // tag store access and result
    hbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .set_index  (set_index),
        .way_index  (way_index),
        .hit        (hit),
        .needs_fill (needs_fill)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for hashed_block_cache_timestamp_lru
// drives lookup, pin, unpin and unused-code beats into the tag store and checks each
// result beat against a behavioral mirror of the tags, valid flags and
// recency stamps; request pacing varies by phase, and the result side
// cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

// mirror of the tag store plus the queue of replies it predicts
class tag_store_scoreboard;

    typedef struct packed {
        logic [2:0] set_no;
        logic [1:0] way_no;
        logic       hit;
        logic       fill;
    } reply_t;

    logic [15:0] dev_tag   [hbc_pkg::SETS*hbc_pkg::WAYS];
    logic [31:0] blk_tag   [hbc_pkg::SETS*hbc_pkg::WAYS];
    logic        filled    [hbc_pkg::SETS*hbc_pkg::WAYS];
    logic [31:0] last_used [hbc_pkg::SETS*hbc_pkg::WAYS];
    reply_t      pending_replies [$];
    int          errors;
    int          n_hits;
    int          n_misses;
    int          n_pins;
    int          n_unpins;
    int          n_unused;
    int          n_replies;

    function new();
        for (int i = 0; i < hbc_pkg::SETS*hbc_pkg::WAYS; i++)
        begin
            dev_tag[i]   = '0;
            blk_tag[i]   = '0;
            filled[i]    = 1'b0;
            last_used[i] = '0;
        end
        errors    = 0;
        n_hits    = 0;
        n_misses  = 0;
        n_pins    = 0;
        n_unpins  = 0;
        n_unused  = 0;
        n_replies = 0;
    endfunction

    // apply one accepted request to the mirror and queue its reply
    function void note_request(input logic [1:0] f, input logic [15:0] dev,
                               input logic [31:0] blk, input logic [1:0] wsel,
                               input logic [31:0] now);
        reply_t      r;
        int          base;
        int          e;
        int          victim;
        logic [31:0] oldest;
        bit          found;
        r      = '0;
        base   = int'(blk % hbc_pkg::SETS) * hbc_pkg::WAYS;
        found  = 1'b0;
        victim = 0;
        oldest = last_used[base];
        e      = base;
        r.set_no = 3'(blk % hbc_pkg::SETS);
        if (f == hbc_pkg::FUNC_LOOKUP)
        begin
            // scan ways in order; older-or-equal stamps move the victim later
            for (int w = 0; w < hbc_pkg::WAYS; w++)
            begin
                if (!found)
                begin
                    if (dev_tag[base+w] == dev && blk_tag[base+w] == blk)
                    begin
                        found    = 1'b1;
                        r.way_no = 2'(w);
                    end
                    else if (last_used[base+w] <= oldest)
                    begin
                        oldest = last_used[base+w];
                        victim = w;
                    end
                end
            end
            if (found)
            begin
                e     = base + int'(r.way_no);
                r.hit = 1'b1;
                n_hits++;
            end
            else
            begin
                r.way_no   = 2'(victim);
                e          = base + victim;
                dev_tag[e] = dev;
                blk_tag[e] = blk;
                filled[e]  = 1'b0;
                n_misses++;
            end
            last_used[e] = now;
            r.fill       = !filled[e];
            filled[e]    = 1'b1;
        end
        else if (f == hbc_pkg::FUNC_PIN || f == hbc_pkg::FUNC_UNPIN)
        begin
            r.way_no = wsel;
            if (int'(wsel) < hbc_pkg::WAYS)
                last_used[base + int'(wsel)] = (f == hbc_pkg::FUNC_PIN) ? now : 32'd0;
            if (f == hbc_pkg::FUNC_PIN)
                n_pins++;
            else
                n_unpins++;
        end
        else
        begin
            // unused code answers with all fields zero
            r = '0;
            n_unused++;
        end
        pending_replies.push_back(r);
    endfunction

    // compare one result beat with the oldest pending reply
    function void check_reply(input logic [2:0] s, input logic [1:0] w,
                              input logic h, input logic nf);
        reply_t x;
        if (pending_replies.size() == 0)
        begin
            $display("%0t: unexpected result beat set %0d way %0d hit %0d fill %0d",
                     $time, s, w, h, nf);
            errors++;
            return;
        end
        x = pending_replies.pop_front();
        n_replies++;
        if (s !== x.set_no)
        begin
            $display("%0t: set_index expected %0d actual %0d", $time, x.set_no, s);
            errors++;
        end
        if (w !== x.way_no)
        begin
            $display("%0t: way_index expected %0d actual %0d", $time, x.way_no, w);
            errors++;
        end
        if (h !== x.hit)
        begin
            $display("%0t: hit expected %0d actual %0d", $time, x.hit, h);
            errors++;
        end
        if (nf !== x.fill)
        begin
            $display("%0t: needs_fill expected %0d actual %0d", $time, x.fill, nf);
            errors++;
        end
    endfunction

    function int pending();
        return pending_replies.size();
    endfunction

endclass

module testbench;

    localparam int POOL = 48;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  func         = '0;
    logic [15:0] device       = '0;
    logic [31:0] block_number = '0;
    logic [1:0]  way_select   = '0;
    logic [31:0] current_time = '0;
    logic        busy;
    logic        done;
    logic [2:0]  set_index;
    logic [1:0]  way_index;
    logic        hit;
    logic        needs_fill;

    tag_store_scoreboard book;
    logic [15:0] pool_dev [POOL];
    logic [31:0] pool_blk [POOL];
    logic [31:0] tick;

    hashed_block_cache_timestamp_lru uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .device       (device),
        .block_number (block_number),
        .way_select   (way_select),
        .current_time (current_time),
        .done         (done),
        .set_index    (set_index),
        .way_index    (way_index),
        .hit          (hit),
        .needs_fill   (needs_fill)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result beats are taken at the edge that ends their cycle
    always @(posedge clk)
    begin
        if (rst_n && done && book != null)
            book.check_reply(set_index, way_index, hit, needs_fill);
    end

    // present one request beat and hold it until accepted
    task automatic issue(input logic [1:0] f, input logic [15:0] dev,
                         input logic [31:0] blk, input logic [1:0] wsel,
                         input logic [31:0] now);
        start        <= 1'b1;
        func         <= f;
        device       <= dev;
        block_number <= blk;
        way_select   <= wsel;
        current_time <= now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        book.note_request(f, dev, blk, wsel, now);
    endtask

    // random sender gaps, pct chance per cycle
    task automatic pace(input int pct);
        while (int'($urandom_range(99)) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold requests until every pending reply is in
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // next recency stamp: mostly rising, sometimes wild or at the extremes
    function automatic logic [31:0] next_stamp();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            tick = $urandom;
        else if (r < 8)
            return 32'd0;
        else if (r < 10)
            return 32'hFFFF_FFFF;
        else
            tick = tick + $urandom_range(1, 5);
        return tick;
    endfunction

    // one random request, mostly lookups on a reused tag pool
    task automatic random_request();
        int          r;
        int          k;
        logic [1:0]  f;
        logic [15:0] dev;
        logic [31:0] blk;
        r   = $urandom_range(99);
        k   = $urandom_range(POOL - 1);
        dev = pool_dev[k];
        blk = pool_blk[k];
        if (r < 62)
            f = hbc_pkg::FUNC_LOOKUP;
        else if (r < 74)
        begin
            f   = hbc_pkg::FUNC_LOOKUP;
            dev = $urandom;
            blk = $urandom;
        end
        else if (r < 85)
            f = hbc_pkg::FUNC_PIN;
        else if (r < 95)
            f = hbc_pkg::FUNC_UNPIN;
        else
            f = hbc_pkg::FUNC_NONE;
        if (f != hbc_pkg::FUNC_LOOKUP && $urandom_range(1) == 1)
        begin
            dev = $urandom;
            blk = $urandom;
        end
        issue(f, dev, blk, 2'($urandom_range(3)), next_stamp());
    endtask

    int pct_for_phase [3] = '{25, 65, 0};
    int waited;

    initial
    begin
        book = new();
        tick = 32'd1000;
        for (int i = 0; i < POOL; i++)
        begin
            pool_dev[i] = (i < 4) ? 16'd0 : 16'($urandom);
            pool_blk[i] = $urandom;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // never-written entry matches device 0 block 0: hit that still needs fill
        issue(hbc_pkg::FUNC_LOOKUP, 16'h0000, 32'h0000_0000, 2'd0, 32'd100);
        issue(hbc_pkg::FUNC_LOOKUP, 16'h0000, 32'h0000_0000, 2'd0, 32'd101);
        // all-ones tags and stamp
        issue(hbc_pkg::FUNC_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        issue(hbc_pkg::FUNC_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 32'd0);
        // fresh set, all stamps zero: ties go to the latest way scanned
        issue(hbc_pkg::FUNC_LOOKUP, 16'd1, 32'd3, 2'd0, 32'd200);
        issue(hbc_pkg::FUNC_LOOKUP, 16'd1, 32'd11, 2'd0, 32'd201);
        issue(hbc_pkg::FUNC_UNPIN, 16'd0, 32'd3, 2'd3, 32'd202);
        issue(hbc_pkg::FUNC_LOOKUP, 16'd1, 32'd19, 2'd0, 32'd203);
        issue(hbc_pkg::FUNC_LOOKUP, 16'd1, 32'd11, 2'd0, 32'd204);
        // pin every way and unpin two of them, stamps at both extremes
        issue(hbc_pkg::FUNC_PIN, 16'hFFFF, 32'hFFFF_FFF7, 2'd0, 32'hFFFF_FFFF);
        issue(hbc_pkg::FUNC_PIN, 16'h0000, 32'h0000_0007, 2'd1, 32'd0);
        issue(hbc_pkg::FUNC_PIN, 16'hA5A5, 32'h8000_000F, 2'd2, 32'd7);
        issue(hbc_pkg::FUNC_PIN, 16'h5A5A, 32'h7FFF_FFFF, 2'd3, 32'hFFFF_FFFE);
        issue(hbc_pkg::FUNC_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 2'd2, 32'hFFFF_FFFF);
        issue(hbc_pkg::FUNC_UNPIN, 16'h0000, 32'h0000_0007, 2'd0, 32'd0);
        issue(hbc_pkg::FUNC_LOOKUP, 16'h1234, 32'h0000_0007, 2'd0, 32'd300);
        issue(hbc_pkg::FUNC_LOOKUP, 16'h4321, 32'hFFFF_FFFF, 2'd1, 32'd301);
        // unused code, once with every field set
        issue(hbc_pkg::FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        issue(hbc_pkg::FUNC_NONE, 16'h0000, 32'h0000_0005, 2'd1, 32'd5);
        // stamp zero on a lookup and a hit right after a miss
        issue(hbc_pkg::FUNC_LOOKUP, 16'h00FF, 32'h0000_0101, 2'd0, 32'd0);
        issue(hbc_pkg::FUNC_LOOKUP, 16'h00FF, 32'h0000_0101, 2'd0, 32'd400);
        drain();

        // random traffic, three pacing phases, drained between them
        for (int p = 0; p < 3; p++)
        begin
            for (int n = 0; n < 210; n++)
            begin
                pace(pct_for_phase[p]);
                random_request();
            end
            drain();
        end

        // final wait for stragglers, bounded
        start  <= 1'b0;
        waited = 0;
        while (book.pending() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (book.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, book.pending());
            book.errors += book.pending();
        end

        $display("covered %0d result beats: %0d lookup hits, %0d misses/allocations,",
                 book.n_replies, book.n_hits, book.n_misses);
        $display("%0d pins, %0d unpins, %0d unused codes, %0d mismatches",
                 book.n_pins, book.n_unpins, book.n_unused, book.errors);
        if (book.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
